// File: hw/rtl/uart_fractional_baud_calculator_top_defines.svh
// ----------------------------------------------------------------------------
// UART fractional baud calculator - assertion macros
// Shared property shorthands for the calculator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UART_FRACTIONAL_BAUD_CALCULATOR_TOP_DEFINES_SVH
`define UART_FRACTIONAL_BAUD_CALCULATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UFBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UFBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ufbc_pkg.sv
// ----------------------------------------------------------------------------
// UART fractional baud calculator - package
// Shared types, constants and the scale search limit table.
// ----------------------------------------------------------------------------
package ufbc_pkg;

   localparam int unsigned DivSteps    = 32;
   localparam int unsigned HiShift     = 3;   // clock / 8
   localparam int unsigned LoShift     = 22;  // clock / 4194304
   localparam int unsigned ScaleSteps  = 14;  // search runs from -7 up to 7
   localparam int unsigned ScaleBias   = 7;

   localparam logic [31:0] ClockHzReset = 32'd32000000;

   localparam logic signed [3:0] ScaleNegSplit = -4'sd3;

   // configuration register indexes
   localparam logic [0:0] CsrClockHz     = 1'b0;
   localparam logic [0:0] CsrDoubleSpeed = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // doubling limit for search step idx (scale = idx - 7)
   function automatic logic [31:0] scale_limit(input logic [3:0] idx);
      logic [31:0] r;
      if (idx < 4'd5) begin
         r = (32'd256 << idx) - 32'd1;
      end else begin
         r = 32'd4095 << (idx - 4'd4);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/ufbc_serial_div.sv
// ----------------------------------------------------------------------------
// UART fractional baud calculator - serial divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module ufbc_serial_div
   import ufbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [31:0]   num,
   input  logic [31:0]   den,
   output logic [31:0]   quotient,
   output unit_stat_type stat
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = ~diff[32];

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (go) begin
         rem_in   = '0;
         quo_in   = num;
         den_in   = den;
         count_in = 5'(DivSteps - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[31:0] : trial[31:0];
         quo_in   = {quo_ff[30:0], ge};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      count_ff <= count_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: hw/rtl/ufbc_scale_search.sv
// ----------------------------------------------------------------------------
// UART fractional baud calculator - scale search
// Walks the doubling limit table one step per cycle to find the scale.
// ----------------------------------------------------------------------------
module ufbc_scale_search
   import ufbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [31:0]        ratio,
   output logic signed [3:0]  scale,
   output unit_stat_type      stat
);

   logic [31:0] ratio_ff, ratio_in;
   logic [3:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic        hit;

   assign hit = (ratio_ff < scale_limit(idx_ff)) || (idx_ff == 4'(ScaleSteps));

   always_comb begin
      ratio_in = ratio_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (go) begin
         ratio_in = ratio;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (hit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      ratio_ff <= ratio_in;
   end

   assign scale     = $signed(idx_ff - 4'(ScaleBias));
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: hw/rtl/uart_fractional_baud_calculator_top.sv
// ----------------------------------------------------------------------------
// UART fractional baud calculator - top level
// Turns a requested baud rate into a 12-bit BSEL divider and a BSCALE
// exponent for the configured peripheral clock and speed mode.
//
// Channels: req_ carries one baud rate per transaction; rsp_ returns one
//   result (accepted flag, divider, scale) per request, in order.
// csr_ is a plain write port: index 0 is clock_hz, index 1 is double_speed.
// Sequence: a rejected rate goes from the range check to the finish state.
//   An accepted rate takes two passes of the bit-serial divider, a scale
//   search between them and prep and load steps before the second pass.
// Throughput: one request at a time; req_stall is high from acceptance
//   until the result has moved into the output register.
// Stall: the result register holds while rsp_stall is high; a finished
//   result waits there while the next request is already being worked on.
// Reset: clock_hz returns to 32000000, double_speed to 0, and no
//   transaction is in flight.
// ----------------------------------------------------------------------------
`include "uart_fractional_baud_calculator_top_defines.svh"

module uart_fractional_baud_calculator_top
   import ufbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_wdata,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_baud_rate,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic [11:0]       rsp_divider,
   output logic signed [3:0] rsp_scale
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_DIV1   = 8'b0000_0100,
      ST_SEARCH = 8'b0000_1000,
      ST_PREP   = 8'b0001_0000,
      ST_LOAD   = 8'b0010_0000,
      ST_DIV2   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] clock_hz_ff, clock_hz_in;
   logic        double_speed_ff, double_speed_in;

   logic [31:0] baud_ff, baud_in;
   logic [31:0] clkp_ff, clkp_in;
   logic [31:0] b_ff, b_in;
   logic signed [3:0] exp_ff, exp_in;

   logic [31:0] div_num_ff, div_num_in;
   logic [31:0] div_den_ff, div_den_in;
   logic        div_go_ff, div_go_in;
   logic        search_go_ff, search_go_in;

   logic              res_accepted_ff, res_accepted_in;
   logic [11:0]       res_divider_ff, res_divider_in;
   logic signed [3:0] res_scale_ff, res_scale_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic [11:0]       rsp_divider_ff, rsp_divider_in;
   logic signed [3:0] rsp_scale_ff, rsp_scale_in;

   logic [31:0]       div_q;
   unit_stat_type     div_stat;
   logic signed [3:0] search_scale;
   unit_stat_type     search_stat;

   logic [31:0] hi_lim, lo_lim;
   logic        reject;
   logic [31:0] baud2;
   logic [3:0]  pos_sh;
   logic [2:0]  neg_sh;
   logic        rsp_take;

   ufbc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .num      (div_num_ff),
      .den      (div_den_ff),
      .quotient (div_q),
      .stat     (div_stat)
   );

   ufbc_scale_search u_search (
      .clock (clock),
      .reset (reset),
      .go    (search_go_ff),
      .ratio (div_q),
      .scale (search_scale),
      .stat  (search_stat)
   );

   // limits are halved without double speed
   assign hi_lim = double_speed_ff ? (clock_hz_ff >> HiShift) : (clock_hz_ff >> (HiShift + 1));
   assign lo_lim = double_speed_ff ? (clock_hz_ff >> LoShift) : (clock_hz_ff >> (LoShift + 1));
   assign reject = (baud_ff == '0) || (baud_ff > hi_lim) || (baud_ff < lo_lim);
   assign baud2  = double_speed_ff ? baud_ff : {baud_ff[30:0], 1'b0};

   assign pos_sh = 4'(exp_ff + 4'sd3);
   assign neg_sh = 3'(4'sd0 - exp_ff - 4'sd3);

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      clock_hz_in     = clock_hz_ff;
      double_speed_in = double_speed_ff;
      if (csr_write) begin
         case (csr_index)
            CsrClockHz:     clock_hz_in     = csr_wdata;
            CsrDoubleSpeed: double_speed_in = csr_wdata[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      baud_in         = baud_ff;
      clkp_in         = clkp_ff;
      b_in            = b_ff;
      exp_in          = exp_ff;
      div_num_in      = div_num_ff;
      div_den_in      = div_den_ff;
      div_go_in       = 1'b0;
      search_go_in    = 1'b0;
      res_accepted_in = res_accepted_ff;
      res_divider_in  = res_divider_ff;
      res_scale_in    = res_scale_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_take;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_divider_in  = rsp_divider_ff;
      rsp_scale_in    = rsp_scale_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               baud_in  = req_baud_rate;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (reject) begin
               res_accepted_in = 1'b0;
               res_divider_in  = '0;
               res_scale_in    = '0;
               state_in        = ST_FINISH;
            end else begin
               baud_in    = baud2;
               div_num_in = clock_hz_ff;
               div_den_in = baud2;
               div_go_in  = 1'b1;
               state_in   = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_stat.done) begin
               search_go_in = 1'b1;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_stat.done) begin
               exp_in   = search_scale;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            clkp_in  = clock_hz_ff - {baud_ff[28:0], 3'b000};
            b_in     = baud_ff << pos_sh;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (exp_ff <= ScaleNegSplit) begin
               div_num_in = (clkp_ff << neg_sh) + (baud_ff >> 1);
               div_den_in = baud_ff;
            end else if (exp_ff[3]) begin
               div_num_in = clkp_ff + (b_ff >> 1);
               div_den_in = b_ff;
            end else begin
               div_num_in = clock_hz_ff + (b_ff >> 1);
               div_den_in = b_ff;
            end
            div_go_in = 1'b1;
            state_in  = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_stat.done) begin
               res_accepted_in = 1'b1;
               // non-negative scales subtract one from the rounded quotient
               res_divider_in  = div_q[11:0] - {11'd0, ~exp_ff[3]};
               res_scale_in    = exp_ff;
               state_in        = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = res_accepted_ff;
               rsp_divider_in  = res_divider_ff;
               rsp_scale_in    = res_scale_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         clock_hz_ff     <= ClockHzReset;
         double_speed_ff <= 1'b0;
         div_go_ff       <= 1'b0;
         search_go_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clock_hz_ff     <= clock_hz_in;
         double_speed_ff <= double_speed_in;
         div_go_ff       <= div_go_in;
         search_go_ff    <= search_go_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      baud_ff         <= baud_in;
      clkp_ff         <= clkp_in;
      b_ff            <= b_in;
      exp_ff          <= exp_in;
      div_num_ff      <= div_num_in;
      div_den_ff      <= div_den_in;
      res_accepted_ff <= res_accepted_in;
      res_divider_ff  <= res_divider_in;
      res_scale_ff    <= res_scale_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_divider_ff  <= rsp_divider_in;
      rsp_scale_ff    <= rsp_scale_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_divider  = rsp_divider_ff;
   assign rsp_scale    = rsp_scale_ff;

   `UFBC_ASSERT_NEXT(a_accept_to_check, req_valid && !req_stall, state_ff == ST_CHECK,
      "accepted request did not enter range check")
   `UFBC_ASSERT_NOW(a_reject_zero_fields, rsp_valid && !rsp_accepted,
      rsp_divider == 12'd0 && rsp_scale == 4'sd0, "rejected result carries nonzero fields")
   `UFBC_ASSERT_NOW(a_scale_range, rsp_valid && rsp_accepted, rsp_scale != -4'sd8,
      "scale outside -7..7")
   `UFBC_ASSERT_NOW(a_div_start_idle, div_go_ff, !div_stat.busy && !search_stat.busy,
      "divider restarted while a unit is busy")
   `UFBC_ASSERT_NOW(a_div_done_state, div_stat.done,
      state_ff == ST_DIV1 || state_ff == ST_DIV2, "divider finished outside a divide state")

endmodule

// File: bench/uart_fractional_baud_calculator_top_tb.sv
// ----------------------------------------------------------------------------
// UART fractional baud calculator - testbench
// Sends baud rates through the request channel under a series of clock and
// double-speed settings and compares each divider/scale result against an
// in-bench BSEL/BSCALE calculation. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module uart_fractional_baud_calculator_top_tb
   import ufbc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] MinRateDiv    = 32'd4194304;
   localparam logic [31:0] BselLimitInit = 32'hFFF >> 4;
   localparam int          WatchdogLimit = 4000;
   localparam int          DrainCycles   = 100;
   localparam int          NumPhases     = 10;

   typedef struct packed {
      logic              accepted;
      logic [11:0]       divider;
      logic signed [3:0] scale;
   } baud_result_type;

   logic              clock;
   logic              reset         = 1'b1;
   logic              csr_write     = 1'b0;
   logic [0:0]        csr_index     = CsrClockHz;
   logic [31:0]       csr_wdata     = '0;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [31:0]       req_baud_rate = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic              rsp_accepted;
   logic [11:0]       rsp_divider;
   logic signed [3:0] rsp_scale;

   // shadow of the block's registers, changed only while it is idle
   logic [31:0]     clock_hz_cfg     = ClockHzReset;
   logic            double_speed_cfg = 1'b0;

   logic [31:0]     baud_pending_q[$];
   baud_result_type bsel_expect_q[$];
   baud_result_type bsel_want;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              idle_cycles    = 0;
   int              errors         = 0;

   uart_fractional_baud_calculator_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_baud_rate (req_baud_rate),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accepted  (rsp_accepted),
      .rsp_divider   (rsp_divider),
      .rsp_scale     (rsp_scale)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // divide by zero gives all ones, like a plain serial divider
   function automatic logic [31:0] div_or_ones(input logic [31:0] n, input logic [31:0] d);
      if (d == 32'd0) begin
         return 32'hFFFF_FFFF;
      end
      return n / d;
   endfunction

   function automatic baud_result_type calc_bsel(input logic [31:0] rate,
                                                 input logic [31:0] clk,
                                                 input logic        ds);
      baud_result_type r;
      logic [31:0]     hi_rate, lo_rate, b, lim, ratio, c, num, sb, q;
      int              e;
      r       = '0;
      hi_rate = clk >> 3;
      lo_rate = clk / MinRateDiv;
      if (!ds) begin
         hi_rate = hi_rate >> 1;
         lo_rate = lo_rate >> 1;
      end
      if (rate == 32'd0 || rate > hi_rate || rate < lo_rate) begin
         return r;
      end
      b     = ds ? rate : (rate << 1);
      lim   = BselLimitInit;
      ratio = div_or_ones(clk, b);
      e     = -7;
      while (e < 7 && !(ratio < lim)) begin
         lim = lim << 1;
         if (e < -3) begin
            lim = lim | 32'd1;
         end
         e++;
      end
      if (e < 0) begin
         c = clk - (b << 3);
         if (e <= ScaleNegSplit) begin
            num = c << (-e - 3);
            q   = div_or_ones(num + (b >> 1), b);
         end else begin
            sb = b << (e + 3);
            q  = div_or_ones(c + (sb >> 1), sb);
         end
      end else begin
         sb = b << (e + 3);
         q  = div_or_ones(clk + (sb >> 1), sb) - 32'd1;
      end
      r.accepted = 1'b1;
      r.divider  = q[11:0];
      r.scale    = e[3:0];
      return r;
   endfunction

   // mostly attainable rates spread over every scale, some boundaries and noise
   function automatic logic [31:0] pick_rate(input logic [31:0] clk, input logic ds);
      logic [31:0] hi_rate, lo_rate, top, rate;
      int          roll;
      hi_rate = ds ? (clk >> 3) : (clk >> 4);
      lo_rate = ds ? (clk / MinRateDiv) : ((clk / MinRateDiv) >> 1);
      roll    = $urandom_range(0, 99);
      if (roll < 8) begin
         rate = $urandom;
      end else if (roll < 18 || hi_rate == 32'd0) begin
         case ($urandom_range(0, 4))
            0:       rate = lo_rate - 32'd1;
            1:       rate = lo_rate;
            2:       rate = hi_rate;
            3:       rate = hi_rate + 32'd1;
            default: rate = $urandom_range(0, 3);
         endcase
      end else begin
         top = hi_rate >> $urandom_range(0, 20);
         if (top == 32'd0) begin
            top = 32'd1;
         end
         rate = top - $urandom_range(0, top >> 1);
         if (rate < lo_rate) begin
            rate = lo_rate;
         end
         if (rate == 32'd0) begin
            rate = 32'd1;
         end
      end
      return rate;
   endfunction

   task automatic wait_drained();
      while (baud_pending_q.size() != 0 || req_valid || bsel_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            bsel_expect_q.push_back(calc_bsel(req_baud_rate, clock_hz_cfg, double_speed_cfg));
         end
         if (baud_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_baud_rate <= baud_pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (bsel_expect_q.size() == 0) begin
               $display("%0t: unexpected result transaction, accepted %0b divider %0d scale %0d",
                        $time, rsp_accepted, rsp_divider, rsp_scale);
               errors++;
            end else begin
               bsel_want = bsel_expect_q.pop_front();
               if (rsp_accepted !== bsel_want.accepted) begin
                  $display("%0t: accepted mismatch, expected %0b, got %0b",
                           $time, bsel_want.accepted, rsp_accepted);
                  errors++;
               end
               if (rsp_divider !== bsel_want.divider) begin
                  $display("%0t: divider mismatch, expected %0d, got %0d",
                           $time, bsel_want.divider, rsp_divider);
                  errors++;
               end
               if (rsp_scale !== bsel_want.scale) begin
                  $display("%0t: scale mismatch, expected %0d, got %0d",
                           $time, bsel_want.scale, rsp_scale);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [31:0] clk_set;
      logic        ds_set;
      int          n_items;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NumPhases; p++) begin
         wait_drained();
         n_items = 140;
         clk_set = clock_hz_cfg;
         ds_set  = double_speed_cfg;
         case (p)
            1: begin clk_set = 32'd32000000; ds_set = 1'b1; end
            2: begin clk_set = 32'hFFFF_FFFF; ds_set = 1'b1; end
            3: begin clk_set = 32'hFFFF_FFFF; ds_set = 1'b0; end
            4: begin clk_set = 32'd1;         ds_set = 1'b1; n_items = 20; end
            5: begin clk_set = 32'd0;         ds_set = 1'b0; n_items = 20; end  // clock of zero
            6: begin clk_set = 32'd14745600;  ds_set = 1'b1; end
            7: begin clk_set = 32'd2000000;   ds_set = 1'b0; end
            8: begin clk_set = $urandom_range(100000, 32'hFFFF_FFFF); ds_set = 1'($urandom); end
            9: begin clk_set = $urandom; ds_set = 1'($urandom); end
            default: ;
         endcase
         // the first phase runs on the reset values of the registers
         if (p > 0) begin
            @(posedge clock);
            csr_write <= 1'b1;
            csr_index <= CsrClockHz;
            csr_wdata <= clk_set;
            @(posedge clock);
            csr_index <= CsrDoubleSpeed;
            csr_wdata <= {31'd0, ds_set};
            @(posedge clock);
            csr_write <= 1'b0;
            clock_hz_cfg     = clk_set;
            double_speed_cfg = ds_set;
         end
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (p == 0) begin
            // 32 MHz, normal speed: attainable range is 3 .. 2000000
            baud_pending_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'd2000000, 32'd2000001, 32'd1999999,
                               32'd300, 32'd1200, 32'd9600, 32'd19200, 32'd57600,
                               32'd115200, 32'd230400, 32'd921600, 32'd1000000};
         end
         repeat (n_items) baud_pending_q.push_back(pick_rate(clock_hz_cfg, double_speed_cfg));
      end
      wait_drained();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
